FILE: rtl/qsed_pkg.sv
// ----------------------------------------------------------------------------
// qsed_pkg
// Types, character codes and helpers shared by the quoted string decoder.
// ----------------------------------------------------------------------------
package qsed_pkg;

    localparam int CH_W        = 21;
    localparam int DC_W        = 3;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_BSNL,
        MODE_HEX,
        MODE_UNI,
        MODE_OCT
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            final_req;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_char;
        t_kind           kind;
        logic            run_last;
    } t_out_item;

    // results of one input word, n of them valid from index 0
    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] item;
        logic [1:0]                  n;
    } t_res_set;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // character codes
    localparam logic [CH_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CH_W-1:0] CH_BSLASH = 21'h5c;
    localparam logic [CH_W-1:0] CH_NL     = 21'h0a;
    localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CH_W-1:0] CH_LO_A   = 21'h61;
    localparam logic [CH_W-1:0] CH_LO_B   = 21'h62;
    localparam logic [CH_W-1:0] CH_LO_F   = 21'h66;
    localparam logic [CH_W-1:0] CH_LO_N   = 21'h6e;
    localparam logic [CH_W-1:0] CH_LO_R   = 21'h72;
    localparam logic [CH_W-1:0] CH_LO_T   = 21'h74;
    localparam logic [CH_W-1:0] CH_LO_U   = 21'h75;
    localparam logic [CH_W-1:0] CH_LO_V   = 21'h76;
    localparam logic [CH_W-1:0] CH_LO_X   = 21'h78;
    localparam logic [CH_W-1:0] CH_BEL    = 21'h07;
    localparam logic [CH_W-1:0] CH_BS     = 21'h08;
    localparam logic [CH_W-1:0] CH_FF     = 21'h0c;
    localparam logic [CH_W-1:0] CH_LF     = 21'h0a;
    localparam logic [CH_W-1:0] CH_CR     = 21'h0d;
    localparam logic [CH_W-1:0] CH_HT     = 21'h09;
    localparam logic [CH_W-1:0] CH_VT     = 21'h0b;

    function automatic t_hex hex_digit(logic [CH_W-1:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = c[3:0];
        if (c >= 21'h30 && c <= 21'h39) begin
            h.val = c[3:0];
        end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_oct(logic [CH_W-1:0] c);
        return (c >= 21'h30 && c <= 21'h37);
    endfunction

    // append one result, ignored once the set is full
    function automatic t_res_set push_res(t_res_set s, logic [CH_W-1:0] c, t_kind k);
        if (s.n < 2'(MAX_RESULTS)) begin
            s.item[s.n].out_char = (k == KIND_CHAR) ? c : '0;
            s.item[s.n].kind     = k;
            s.item[s.n].run_last = 1'b0;
            s.n                  = s.n + 2'd1;
        end
        return s;
    endfunction

endpackage

FILE: rtl/qsed_step.sv
// ----------------------------------------------------------------------------
// qsed_step
// Decodes one character against the current mode: next mode, escape
// accumulator and the results it produces.
// ----------------------------------------------------------------------------
module qsed_step
    import qsed_pkg::*;
#(
    parameter int UNICODE_DIGITS = 4,
    parameter int OCTAL_DIGITS   = 3,
    parameter int ACC_W          = 16
) (
    input  t_mode            i_mode,
    input  logic [ACC_W-1:0] i_accum,
    input  logic [DC_W-1:0]  i_digit_count,
    input  t_in_item         i_in,
    output t_mode            o_mode,
    output logic [ACC_W-1:0] o_accum,
    output logic [DC_W-1:0]  o_digit_count,
    output t_res_set         o_res
);

    localparam int EXT_W = (ACC_W > CH_W) ? ACC_W : CH_W;

    function automatic logic [CH_W-1:0] acc_char(logic [ACC_W-1:0] acc);
        logic [EXT_W-1:0] wide;
        wide = EXT_W'(acc);
        return wide[CH_W-1:0];
    endfunction

    function automatic t_res_set body_res(logic [CH_W-1:0] c, t_res_set s);
        if (c == CH_QUOTE) begin
            return push_res(s, '0, KIND_DONE);
        end else if (c == CH_BSLASH) begin
            return s;
        end
        return push_res(s, c, KIND_CHAR);
    endfunction

    function automatic t_mode body_mode(logic [CH_W-1:0] c);
        if (c == CH_QUOTE) begin
            return MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            return MODE_ESC;
        end
        return MODE_BODY;
    endfunction

    // a numeric escape with no digits gives back its letter
    function automatic t_res_set flush_res(t_mode m, logic [ACC_W-1:0] acc,
                                           logic [DC_W-1:0] dc, t_res_set s);
        if (m == MODE_HEX || m == MODE_UNI) begin
            if (dc == '0) begin
                return push_res(s, (m == MODE_HEX) ? CH_LO_X : CH_LO_U, KIND_CHAR);
            end
            return push_res(s, acc_char(acc), KIND_CHAR);
        end else if (m == MODE_OCT) begin
            return push_res(s, acc_char(acc), KIND_CHAR);
        end
        return s;
    endfunction

    t_hex             w_hex;
    logic [CH_W-1:0]  w_c;
    logic [DC_W-1:0]  w_dc_inc;
    logic [ACC_W-1:0] w_acc_hex;
    logic [ACC_W-1:0] w_acc_oct;

    assign w_c       = i_in.ch;
    assign w_hex     = hex_digit(w_c);
    assign w_dc_inc  = i_digit_count + DC_W'(1);
    assign w_acc_hex = {i_accum[ACC_W-5:0], w_hex.val};
    assign w_acc_oct = {i_accum[ACC_W-4:0], w_c[2:0]};

    always_comb begin
        t_mode            m;
        logic [ACC_W-1:0] acc;
        logic [DC_W-1:0]  dc;
        t_res_set         s;

        m   = i_mode;
        acc = i_accum;
        dc  = i_digit_count;
        s   = '0;

        unique case (i_mode)
            MODE_IDLE: begin
                if (w_c == CH_QUOTE) begin
                    m = MODE_BODY;
                end else begin
                    s = push_res(s, '0, KIND_ERR);
                end
            end
            MODE_BODY: begin
                s = body_res(w_c, s);
                m = body_mode(w_c);
            end
            MODE_ESC: begin
                m   = MODE_BODY;
                acc = '0;
                dc  = '0;
                unique case (w_c)
                    CH_LO_A: s = push_res(s, CH_BEL, KIND_CHAR);
                    CH_LO_B: s = push_res(s, CH_BS, KIND_CHAR);
                    CH_LO_F: s = push_res(s, CH_FF, KIND_CHAR);
                    CH_LO_N: s = push_res(s, CH_LF, KIND_CHAR);
                    CH_LO_R: s = push_res(s, CH_CR, KIND_CHAR);
                    CH_LO_T: s = push_res(s, CH_HT, KIND_CHAR);
                    CH_LO_V: s = push_res(s, CH_VT, KIND_CHAR);
                    CH_NL: begin
                        s = push_res(s, CH_SPACE, KIND_CHAR);
                        m = MODE_BSNL;
                    end
                    CH_LO_X: m = MODE_HEX;
                    CH_LO_U: m = MODE_UNI;
                    default: begin
                        if (is_oct(w_c)) begin
                            acc = ACC_W'(w_c[2:0]);
                            dc  = DC_W'(1);
                            if (OCTAL_DIGITS <= 1) begin
                                s   = push_res(s, acc_char(acc), KIND_CHAR);
                                acc = '0;
                                dc  = '0;
                            end else begin
                                m = MODE_OCT;
                            end
                        end else begin
                            s = push_res(s, w_c, KIND_CHAR);
                        end
                    end
                endcase
            end
            MODE_BSNL: begin
                // spaces and tabs after a backslash-newline are dropped
                if (w_c != CH_SPACE && w_c != CH_TAB) begin
                    s = body_res(w_c, s);
                    m = body_mode(w_c);
                end
            end
            MODE_HEX: begin
                if (w_hex.ok) begin
                    acc = ACC_W'(w_acc_hex[7:0]);
                    if (dc != '1) begin
                        dc = w_dc_inc;
                    end
                end else begin
                    s   = flush_res(i_mode, i_accum, i_digit_count, s);
                    acc = '0;
                    dc  = '0;
                    s   = body_res(w_c, s);
                    m   = body_mode(w_c);
                end
            end
            MODE_UNI: begin
                if (w_hex.ok) begin
                    acc = w_acc_hex;
                    dc  = w_dc_inc;
                    if (w_dc_inc >= DC_W'(UNICODE_DIGITS)) begin
                        s   = push_res(s, acc_char(w_acc_hex), KIND_CHAR);
                        acc = '0;
                        dc  = '0;
                        m   = MODE_BODY;
                    end
                end else begin
                    s   = flush_res(i_mode, i_accum, i_digit_count, s);
                    acc = '0;
                    dc  = '0;
                    s   = body_res(w_c, s);
                    m   = body_mode(w_c);
                end
            end
            MODE_OCT: begin
                if (is_oct(w_c)) begin
                    acc = w_acc_oct;
                    dc  = w_dc_inc;
                    if (w_dc_inc >= DC_W'(OCTAL_DIGITS)) begin
                        s   = push_res(s, acc_char(w_acc_oct), KIND_CHAR);
                        acc = '0;
                        dc  = '0;
                        m   = MODE_BODY;
                    end
                end else begin
                    s   = flush_res(i_mode, i_accum, i_digit_count, s);
                    acc = '0;
                    dc  = '0;
                    s   = body_res(w_c, s);
                    m   = body_mode(w_c);
                end
            end
            default: begin
                m   = MODE_IDLE;
                acc = '0;
                dc  = '0;
                s   = push_res(s, '0, KIND_ERR);
            end
        endcase

        // end of input inside the string: flush what is pending, then error
        if (i_in.final_req && m != MODE_IDLE) begin
            if (m == MODE_ESC) begin
                s = push_res(s, CH_BSLASH, KIND_CHAR);
            end else begin
                s = flush_res(m, acc, dc, s);
            end
            s   = push_res(s, '0, KIND_ERR);
            m   = MODE_IDLE;
            acc = '0;
            dc  = '0;
        end

        if (s.n != 2'd0) begin
            s.item[s.n - 2'd1].run_last = 1'b1;
        end

        o_mode        = m;
        o_accum       = acc;
        o_digit_count = dc;
        o_res         = s;
    end

endmodule

FILE: rtl/qsed_queue.sv
// ----------------------------------------------------------------------------
// qsed_queue
// Result queue: takes up to three results from one word, delivers one a cycle while the output is ready.
// ----------------------------------------------------------------------------
module qsed_queue
    import qsed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_res_set  i_res,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_RESULTS);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_out_item        r_q [QUEUE_DEPTH];
    t_out_item        n_q [QUEUE_DEPTH];
    t_out_item        w_shift [QUEUE_DEPTH];
    logic             w_pop;
    logic [CNT_W-1:0] w_base;
    logic [CNT_W-1:0] w_push_n;

    assign o_valid  = (r_count != '0);
    assign o_item   = r_q[0];
    assign o_space  = (r_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign w_pop    = o_valid && i_ready;
    assign w_base   = r_count - CNT_W'(w_pop);
    assign w_push_n = i_push ? CNT_W'(i_res.n) : '0;
    assign n_count  = w_base + w_push_n;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            w_shift[i] = r_q[i+1];
        end
        w_shift[QUEUE_DEPTH-1] = r_q[QUEUE_DEPTH-1];
    end

    always_comb begin
        logic [CNT_W-1:0] slot;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_q[i] = w_pop ? w_shift[i] : r_q[i];
            slot   = CNT_W'(i) - w_base;
            if (CNT_W'(i) >= w_base && slot < w_push_n) begin
                n_q[i] = i_res.item[slot[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS)))
        else $error("word pushed without room for all its results");

endmodule

FILE: rtl/quoted_string_escape_decoder_unit.sv
// Latency: the first result of an accepted word is offered the cycle after it if the queue was empty.
// Throughput: one word a cycle while each word gives at most one result and the
// output takes it; a word with more results keeps the output busy until all are taken, as the
// four-entry result queue accepts a word only while it holds one result or none.
// Reset (i_rst_n low, synchronous): mode idle, escape state cleared, queue empty.
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_unit
// Decodes a double-quoted string with backslash escapes, one character a word.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_unit
    import qsed_pkg::*;
#(
    parameter int UNICODE_DIGITS = 4,
    parameter int OCTAL_DIGITS   = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int ACC_W = (4 * UNICODE_DIGITS > 9) ? 4 * UNICODE_DIGITS : 9;

    t_mode            r_mode;
    logic [ACC_W-1:0] r_accum;
    logic [DC_W-1:0]  r_digit_count;
    t_mode            n_mode;
    logic [ACC_W-1:0] n_accum;
    logic [DC_W-1:0]  n_digit_count;
    t_res_set         w_res;
    logic             w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    qsed_step #(
        .UNICODE_DIGITS (UNICODE_DIGITS),
        .OCTAL_DIGITS   (OCTAL_DIGITS),
        .ACC_W          (ACC_W)
    ) u_step (
        .i_mode        (r_mode),
        .i_accum       (r_accum),
        .i_digit_count (r_digit_count),
        .i_in          (i_in),
        .o_mode        (n_mode),
        .o_accum       (n_accum),
        .o_digit_count (n_digit_count),
        .o_res         (w_res)
    );

    qsed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_accum       <= '0;
            r_digit_count <= '0;
        end else if (w_accept) begin
            r_mode        <= n_mode;
            r_accum       <= n_accum;
            r_digit_count <= n_digit_count;
        end
    end

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.final_req) |=> (r_mode == MODE_IDLE))
        else $error("last word did not return decoder to idle");

    a_uni_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_UNI) |-> (r_digit_count < DC_W'(UNICODE_DIGITS)))
        else $error("unicode escape kept too many digits");

    a_oct_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OCT) |->
            (r_digit_count != '0 && r_digit_count < DC_W'(OCTAL_DIGITS)))
        else $error("octal escape digit count out of range");

endmodule

FILE: dv/qsed_decode_checker.sv
// ----------------------------------------------------------------------------
// qsed_decode_checker
// Watches both channels of the quoted string decoder. Every word the block
// accepts is run through a local decoder model, and the results it yields are
// queued. Every result the block hands out is then compared, field by field,
// with the oldest queued one. Failures are counted and passed to the top.
// ----------------------------------------------------------------------------
module qsed_decode_checker
    import qsed_pkg::*;
#(
    parameter int UNICODE_DIGITS = 4,
    parameter int OCTAL_DIGITS   = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CH_W-1:0] CH_ZERO  = 21'h30;
    localparam logic [CH_W-1:0] CH_SEVEN = 21'h37;
    localparam logic [CH_W-1:0] CH_NINE  = 21'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 21'h41;
    localparam logic [CH_W-1:0] CH_UP_F  = 21'h46;

    localparam logic [31:0] HEX_KEEP_MASK = 32'hFF;
    localparam logic [31:0] UNI_KEEP_MASK = 32'hFF_FFFF;
    localparam logic [31:0] OCT_KEEP_MASK = 32'hFFF;

    // decoder state as the model sees it
    t_mode       dec_mode;
    logic [31:0] esc_value;
    int unsigned esc_digits;

    t_out_item   word_results[$];
    t_out_item   expected_results[$];
    t_out_item   want;
    int          fails;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
        dec_mode     = MODE_IDLE;
        esc_value    = '0;
        esc_digits   = 0;
    end

    function automatic int hex_nibble(logic [CH_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LO_A && c <= CH_LO_F) begin
            return int'(c - CH_LO_A) + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            return int'(c - CH_UP_A) + 10;
        end
        return -1;
    endfunction

    function automatic bit is_octal_digit(logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    // at most three results a word, anything beyond is dropped
    task automatic add_result(logic [31:0] v, t_kind k);
        t_out_item r;
        if (word_results.size() < MAX_RESULTS) begin
            r.out_char = (k == KIND_CHAR) ? v[CH_W-1:0] : '0;
            r.kind     = k;
            r.run_last = 1'b0;
            word_results.push_back(r);
        end
    endtask

    task automatic decode_body(logic [CH_W-1:0] c);
        if (c == CH_QUOTE) begin
            add_result('0, KIND_DONE);
            dec_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            add_result(32'(c), KIND_CHAR);
        end
    endtask

    task automatic decode_escape(logic [CH_W-1:0] c);
        dec_mode   = MODE_BODY;
        esc_value  = '0;
        esc_digits = 0;
        case (c)
            CH_LO_A: add_result(32'(CH_BEL), KIND_CHAR);
            CH_LO_B: add_result(32'(CH_BS), KIND_CHAR);
            CH_LO_F: add_result(32'(CH_FF), KIND_CHAR);
            CH_LO_N: add_result(32'(CH_LF), KIND_CHAR);
            CH_LO_R: add_result(32'(CH_CR), KIND_CHAR);
            CH_LO_T: add_result(32'(CH_HT), KIND_CHAR);
            CH_LO_V: add_result(32'(CH_VT), KIND_CHAR);
            CH_NL: begin
                add_result(32'(CH_SPACE), KIND_CHAR);
                dec_mode = MODE_BSNL;
            end
            CH_LO_X: dec_mode = MODE_HEX;
            CH_LO_U: dec_mode = MODE_UNI;
            default: begin
                if (is_octal_digit(c)) begin
                    esc_value  = 32'(c - CH_ZERO);
                    esc_digits = 1;
                    if (esc_digits >= OCTAL_DIGITS) begin
                        add_result(esc_value, KIND_CHAR);
                        esc_value  = '0;
                        esc_digits = 0;
                    end else begin
                        dec_mode = MODE_OCT;
                    end
                end else begin
                    add_result(32'(c), KIND_CHAR);
                end
            end
        endcase
    endtask

    // emit whatever a numeric escape has gathered so far
    task automatic flush_escape();
        if (dec_mode == MODE_HEX || dec_mode == MODE_UNI) begin
            if (esc_digits == 0) begin
                add_result(32'((dec_mode == MODE_HEX) ? CH_LO_X : CH_LO_U), KIND_CHAR);
            end else begin
                add_result(esc_value, KIND_CHAR);
            end
        end else if (dec_mode == MODE_OCT) begin
            add_result(esc_value, KIND_CHAR);
        end
        esc_value  = '0;
        esc_digits = 0;
        dec_mode   = MODE_BODY;
    endtask

    task automatic predict_word(t_in_item w);
        int        d;
        t_out_item r;
        word_results.delete();
        case (dec_mode)
            MODE_IDLE: begin
                if (w.ch == CH_QUOTE) begin
                    dec_mode = MODE_BODY;
                end else begin
                    add_result('0, KIND_ERR);
                end
            end
            MODE_BODY: decode_body(w.ch);
            MODE_ESC:  decode_escape(w.ch);
            MODE_BSNL: begin
                if (w.ch != CH_SPACE && w.ch != CH_TAB) begin
                    dec_mode = MODE_BODY;
                    decode_body(w.ch);
                end
            end
            MODE_HEX: begin
                d = hex_nibble(w.ch);
                if (d >= 0) begin
                    esc_value = ((esc_value << 4) | 32'(d)) & HEX_KEEP_MASK;
                    if (esc_digits < 7) begin
                        esc_digits++;
                    end
                end else begin
                    flush_escape();
                    decode_body(w.ch);
                end
            end
            MODE_UNI: begin
                d = hex_nibble(w.ch);
                if (d >= 0) begin
                    esc_value = ((esc_value << 4) | 32'(d)) & UNI_KEEP_MASK;
                    esc_digits++;
                    if (esc_digits >= UNICODE_DIGITS) begin
                        add_result(esc_value, KIND_CHAR);
                        esc_value  = '0;
                        esc_digits = 0;
                        dec_mode   = MODE_BODY;
                    end
                end else begin
                    flush_escape();
                    decode_body(w.ch);
                end
            end
            MODE_OCT: begin
                if (is_octal_digit(w.ch)) begin
                    esc_value = ((esc_value << 3) | 32'(w.ch - CH_ZERO)) & OCT_KEEP_MASK;
                    esc_digits++;
                    if (esc_digits >= OCTAL_DIGITS) begin
                        add_result(esc_value, KIND_CHAR);
                        esc_value  = '0;
                        esc_digits = 0;
                        dec_mode   = MODE_BODY;
                    end
                end else begin
                    flush_escape();
                    decode_body(w.ch);
                end
            end
            default: begin
                dec_mode   = MODE_IDLE;
                esc_value  = '0;
                esc_digits = 0;
                add_result('0, KIND_ERR);
            end
        endcase

        // end of input inside a string: flush, then report the error
        if (w.final_req && dec_mode != MODE_IDLE) begin
            if (dec_mode == MODE_ESC) begin
                add_result(32'(CH_BSLASH), KIND_CHAR);
            end else begin
                flush_escape();
            end
            add_result('0, KIND_ERR);
            dec_mode   = MODE_IDLE;
            esc_value  = '0;
            esc_digits = 0;
        end

        for (int i = 0; i < word_results.size(); i++) begin
            r          = word_results[i];
            r.run_last = (i == word_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_mode   = MODE_IDLE;
            esc_value  = '0;
            esc_digits = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_word(i_in);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: result with none expected: out_char %h kind %0d run_last %b",
                             $time, i_out.out_char, i_out.kind, i_out.run_last);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.out_char !== want.out_char) begin
                        fails++;
                        $display("%0t: out_char expected %h actual %h",
                                 $time, want.out_char, i_out.out_char);
                    end
                    if (i_out.kind !== want.kind) begin
                        fails++;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, i_out.kind);
                    end
                    if (i_out.run_last !== want.run_last) begin
                        fails++;
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.run_last, i_out.run_last);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: dv/quoted_string_escape_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_unit_test
// Drives quoted strings into the decoder: a short directed run over the
// special cases, then random strings with escapes of every sort, truncated
// strings and stray characters, under four idling phases. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_unit_test
    import qsed_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              UNICODE_DIGITS = 4;
    localparam int              OCTAL_DIGITS   = 3;
    localparam int              PHASE_WORDS    = 110;
    localparam logic [CH_W-1:0] CH_MAX         = 21'h10FFFF;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    int fail_count;
    int pending_results;
    int words_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_end;

    quoted_string_escape_decoder_unit #(
        .UNICODE_DIGITS (UNICODE_DIGITS),
        .OCTAL_DIGITS   (OCTAL_DIGITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    qsed_decode_checker #(
        .UNICODE_DIGITS (UNICODE_DIGITS),
        .OCTAL_DIGITS   (OCTAL_DIGITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400_000);
        $display("quoted_string_escape_decoder_unit: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [CH_W-1:0] c, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{ch: c, final_req: fin};
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // a body word now and then carries the end-of-input flag
    task automatic send_body(logic [CH_W-1:0] c);
        send_word(c, $urandom_range(49) == 0);
    endtask

    task automatic send_text(string s, bit fin_on_last);
        for (int i = 0; i < s.len(); i++) begin
            send_word(CH_W'(s[i]), fin_on_last && (i == s.len() - 1));
        end
    endtask

    // the checker's pending count is registered, so drop valid and let it update first
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [CH_W-1:0] rand_plain();
        case ($urandom_range(3))
            0:       return CH_W'($urandom_range(8'h7e, 8'h20));
            1:       return CH_W'($urandom_range(CH_MAX));
            2:       return CH_W'($urandom_range(16'hFFFF, 8'h80));
            default: return CH_W'($urandom_range(8'h1f));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] rand_hex_digit();
        int v;
        v = $urandom_range(21);
        if (v < 10) begin
            return CH_W'("0") + CH_W'(v);
        end else if (v < 16) begin
            return CH_LO_A + CH_W'(v - 10);
        end
        return CH_W'("A") + CH_W'(v - 16);
    endfunction

    function automatic logic [CH_W-1:0] rand_escape_letter();
        case ($urandom_range(6))
            0:       return CH_LO_A;
            1:       return CH_LO_B;
            2:       return CH_LO_F;
            3:       return CH_LO_N;
            4:       return CH_LO_R;
            5:       return CH_LO_T;
            default: return CH_LO_V;
        endcase
    endfunction

    task automatic send_piece();
        case ($urandom_range(9))
            0, 1, 2, 3: send_body(rand_plain());
            4: begin
                send_body(CH_BSLASH);
                send_body(rand_escape_letter());
            end
            5: begin
                send_body(CH_BSLASH);
                send_body(CH_NL);
                repeat ($urandom_range(3)) send_body($urandom_range(1) ? CH_SPACE : CH_TAB);
            end
            6: begin
                send_body(CH_BSLASH);
                send_body(CH_LO_X);
                repeat ($urandom_range(4)) send_body(rand_hex_digit());
            end
            7: begin
                send_body(CH_BSLASH);
                send_body(CH_LO_U);
                repeat ($urandom_range(5)) send_body(rand_hex_digit());
            end
            8: begin
                send_body(CH_BSLASH);
                repeat ($urandom_range(4, 1)) send_body(CH_W'("0") + CH_W'($urandom_range(7)));
            end
            default: begin
                send_body(CH_BSLASH);
                send_body(rand_plain());
            end
        endcase
    endtask

    // mostly whole strings, some cut short, some stray characters
    task automatic send_random_string();
        if ($urandom_range(9) == 0) begin
            send_word(rand_plain(), $urandom_range(9) == 0);
        end else begin
            send_word(CH_QUOTE, 1'b0);
            repeat ($urandom_range(8)) send_piece();
            if ($urandom_range(4) != 0) begin
                send_word(CH_QUOTE, $urandom_range(9) == 0);
            end else begin
                send_word(rand_plain(), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray words in idle, then escapes of each numeric sort
        send_word(CH_MAX, 1'b0);
        send_word('0, 1'b1);
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_MAX, 1'b0);
        send_text("\\xg\\uAf09\\79\\\n \t\"", 1'b0);
        // lone backslash at end of input, then a hex escape cut short
        send_text("\"\\", 1'b1);
        send_text("\"\\x4z", 1'b1);

        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct   = 63;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 63;
                end
                default: begin
                    send_idle_pct   = 8;
                    recv_stall_pct <= 8;
                end
            endcase
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                send_random_string();
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("quoted_string_escape_decoder_unit: match");
        end else begin
            $display("quoted_string_escape_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
